[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the reply line parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rpl_pkg.sv]
// ----------------------------------------------------------------------------
// Reply line parser package
// Types, character codes and the key table shared by the parser files.
// ----------------------------------------------------------------------------
package rpl_pkg;

	localparam int BYTE_W  = 8;
	localparam int KEY_W   = 4;
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = 4;
	localparam int NUM_KEYS = 11;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [KEY_W-1:0]   key_code_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [FRAC_W-1:0]  frac_t;

	// Character codes.
	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_VT    = 8'h0B;
	localparam byte_t CH_FF    = 8'h0C;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_PLUS  = 8'h2B;
	localparam byte_t CH_MINUS = 8'h2D;
	localparam byte_t CH_POINT = 8'h2E;
	localparam byte_t CH_ZERO  = 8'h30;
	localparam byte_t CH_NINE  = 8'h39;
	localparam byte_t CH_SEMI  = 8'h3B;
	localparam byte_t CH_EQUAL = 8'h3D;

	// Key codes with special value handling.
	localparam key_code_t KEY_VX = 4'd1;
	localparam key_code_t KEY_IQ = 4'd2;

	// Two-character keys, indexed by key code.
	localparam logic [2*BYTE_W-1:0] KEY_TABLE [NUM_KEYS] = '{
		"PX", "VX", "IQ", "SO", "EC", "PS", "AC", "DC", "PR", "PA", "SD"
	};

	localparam value_t POS_MAX  = 32'h7FFF_FFFF;
	localparam value_t NEG_MAX  = 32'h8000_0000;
	localparam frac_t  FRAC_MAX = 4'd10;

	// Number scanning phase.
	typedef enum logic [1:0] {
		PH_SKIP_WS,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic      hit;
		key_code_t code;
	} key_match_t;

	// One finished line, ready for the result register.
	typedef struct packed {
		logic      hit;
		key_code_t key_code;
		value_t    value;
		frac_t     frac_digits;
	} result_t;

	function automatic key_match_t key_lookup(input byte_t first, input byte_t second);
		key_match_t m;
		m.hit  = 1'b0;
		m.code = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (!m.hit && KEY_TABLE[k] == {first, second}) begin
				m.hit  = 1'b1;
				m.code = KEY_W'(k);
			end
		end
		return m;
	endfunction

endpackage

[rtl/core/rpl_if.sv]
// ----------------------------------------------------------------------------
// Reply line parser channels
// Valid/ready channels for received bytes and for parsed replies.
// ----------------------------------------------------------------------------
interface rpl_byte_if;
	import rpl_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpl_reply_if;
	import rpl_pkg::*;

	logic      valid;
	logic      ready;
	key_code_t key_code;
	value_t    value;
	frac_t     frac_digits;

	modport source (output valid, output key_code, output value, output frac_digits,
		input ready);
	modport sink (input valid, input key_code, input value, input frac_digits,
		output ready);
endinterface

[rtl/core/ascii_reply_line_parser.sv]
// ----------------------------------------------------------------------------
// ASCII reply line parser
// Turns received reply bytes into key codes with parsed decimal values.
// ----------------------------------------------------------------------------
// The block takes at most one received byte per clock cycle and gives at most one
// reply item per line. A line ends at CR, LF or a semicolon; when a non-empty
// line ends that holds an equals sign and starts with one of the eleven known
// keys, the reply carries the key code, the decimal value after the first
// equals sign (saturated to 32 bits, absolute for VX, a digit mantissa for IQ)
// and, for IQ, the count of digits after the point. A line that reaches
// LINE_BUFFER_SIZE-1 bytes is dropped together with the next non-terminator
// byte. Each byte is taken into an input register and processed from there,
// and a reply appears in the result register in the cycle after its
// terminator is processed. The sustained rate is one byte per cycle while no
// terminator waits; the critical path is the decimal accumulate (times ten
// plus digit, then a 36-bit compare against the saturation limit). Only a
// terminator waits on the result register, so data bytes keep flowing while
// a finished reply is still waiting to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_reply_line_parser #(
	parameter int LINE_BUFFER_SIZE = 96
) (
	input  logic         clk,
	input  logic         arst_n,
	rpl_byte_if.sink     rx,
	rpl_reply_if.source  reply
);
	import rpl_pkg::*;

	logic    valid_s1;
	byte_t   byte_s1;
	logic    take;
	logic    out_free;
	result_t res;

	logic      out_valid_q;
	key_code_t key_code_q;
	value_t    value_q;
	frac_t     frac_q;

	// Input register: the byte waits here until the parser consumes it.
	rpl_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Line state and number scanning; decodes a finished line in the
	// cycle its terminator is consumed.
	rpl_parser #(
		.LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.take     (take),
		.res      (res)
	);

	// Result register. It can be reloaded in the same cycle that the
	// waiting reply is taken.
	assign out_free = !out_valid_q || reply.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.hit) begin
			out_valid_q <= 1'b1;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.hit) begin
			key_code_q <= res.key_code;
			value_q    <= res.value;
			frac_q     <= res.frac_digits;
		end
	end

	assign reply.valid       = out_valid_q;
	assign reply.key_code    = key_code_q;
	assign reply.value       = value_q;
	assign reply.frac_digits = frac_q;

	// A reply is only produced from a consumed line terminator.
	`ASSERT_SAME(a_hit_on_term, clk, arst_n, res.hit,
		valid_s1 && take && (byte_s1 == CH_LF || byte_s1 == CH_CR || byte_s1 == CH_SEMI),
		"reply produced without a consumed terminator")

	// The input side only stalls when a byte is held and the result side is full.
	`ASSERT_SAME(a_stall_cause, clk, arst_n, !rx.ready, valid_s1 && out_valid_q,
		"input stalled without a full result register")

	// A new reply is never dropped: the result register is loaded.
	`ASSERT_NEXT(a_hit_loads, clk, arst_n, res.hit, out_valid_q,
		"result register not loaded after a reply")

	// A waiting reply is never overwritten before it is taken.
	`ASSERT_SAME(a_no_overwrite, clk, arst_n, res.hit, !out_valid_q || reply.ready,
		"reply overwrote a waiting result")

endmodule

[rtl/core/rpl_in_reg.sv]
// ----------------------------------------------------------------------------
// Reply line parser input register
// Registers each received byte; refills in the cycle the parser consumes it.
// ----------------------------------------------------------------------------
module rpl_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	rpl_byte_if.sink       rx,
	input  logic           take,
	output logic           valid_s1,
	output rpl_pkg::byte_t byte_s1
);
	import rpl_pkg::*;

	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

[rtl/core/rpl_parser.sv]
// ----------------------------------------------------------------------------
// Reply line parser core
// Per-byte line state update, decimal accumulation and end-of-line decode.
// ----------------------------------------------------------------------------
module rpl_parser #(
	parameter int LINE_BUFFER_SIZE = 96
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  rpl_pkg::byte_t   byte_s1,
	input  logic             out_free,
	output logic             take,
	output rpl_pkg::result_t res
);
	import rpl_pkg::*;

	localparam int LEN_W = $clog2(LINE_BUFFER_SIZE);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_SIZE - 1);

	logic [LEN_W-1:0] len_q, len_d;
	byte_t            key_first_q, key_first_d;
	byte_t            key_second_q, key_second_d;
	logic             eq_seen_q, eq_seen_d;
	logic             ended_q, ended_d;
	phase_t           phase_q, phase_d;
	logic             neg_q, neg_d;
	value_t           mag_q, mag_d;
	logic             sat_q, sat_d;
	logic             in_frac_q, in_frac_d;
	frac_t            frac_cnt_q, frac_cnt_d;

	logic             is_term, is_ws, is_sign, is_digit, is_point, is_iq;
	logic             to_digits, clear;
	logic [35:0]      acc;
	value_t           lim;
	key_match_t       km;

	assign is_term  = (byte_s1 == CH_LF) || (byte_s1 == CH_CR) || (byte_s1 == CH_SEMI);
	assign is_ws    = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) ||
		(byte_s1 == CH_VT) || (byte_s1 == CH_FF);
	assign is_sign  = (byte_s1 == CH_PLUS) || (byte_s1 == CH_MINUS);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_iq    = (key_first_q == KEY_TABLE[KEY_IQ][15:8]) &&
		(key_second_q == KEY_TABLE[KEY_IQ][7:0]);
	assign is_point = (byte_s1 == CH_POINT) && is_iq && !in_frac_q;

	// Ten times the magnitude plus the new digit, wide enough never to wrap.
	assign acc = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + 36'(byte_s1 - CH_ZERO);
	assign lim = neg_q ? NEG_MAX : POS_MAX;

	// A terminator waits for a free result register, whether or not it produces a result.
	assign take = valid_s1 && (!is_term || out_free);

	always_comb begin
		len_d        = len_q;
		key_first_d  = key_first_q;
		key_second_d = key_second_q;
		eq_seen_d    = eq_seen_q;
		ended_d      = ended_q;
		phase_d      = phase_q;
		neg_d        = neg_q;
		mag_d        = mag_q;
		sat_d        = sat_q;
		in_frac_d    = in_frac_q;
		frac_cnt_d   = frac_cnt_q;
		to_digits    = 1'b0;
		clear        = 1'b0;

		unique case (phase_q)
			PH_SKIP_WS: to_digits = !is_ws && !is_sign;
			PH_SIGN:    to_digits = 1'b1;
			PH_DIGITS:  to_digits = 1'b1;
			PH_DONE:    to_digits = 1'b0;
			default:    to_digits = 1'b0;
		endcase

		if (take) begin
			if (is_term) begin
				clear = (len_q != '0);
			end else if (len_q < LEN_LIMIT) begin
				len_d = len_q + 1'b1;
				if (!ended_q) begin
					if (byte_s1 == CH_NUL) begin
						ended_d = 1'b1;
					end else begin
						if (len_q == LEN_W'(0)) begin
							key_first_d = byte_s1;
						end else if (len_q == LEN_W'(1)) begin
							key_second_d = byte_s1;
						end
						if (!eq_seen_q) begin
							if (byte_s1 == CH_EQUAL) begin
								eq_seen_d = 1'b1;
							end
						end else if (phase_q == PH_SKIP_WS && is_sign) begin
							neg_d   = (byte_s1 == CH_MINUS);
							phase_d = PH_SIGN;
						end else if (to_digits) begin
							if (is_digit) begin
								phase_d = PH_DIGITS;
								if (!sat_q) begin
									if (in_frac_q) begin
										if (frac_cnt_q >= FRAC_MAX || acc > {4'd0, lim}) begin
											phase_d = PH_DONE;
										end else begin
											mag_d      = acc[31:0];
											frac_cnt_d = frac_cnt_q + 1'b1;
										end
									end else if (acc > {4'd0, NEG_MAX}) begin
										sat_d = 1'b1;
									end else begin
										mag_d = acc[31:0];
									end
								end
							end else if (is_point) begin
								phase_d   = PH_DIGITS;
								in_frac_d = 1'b1;
							end else begin
								phase_d = PH_DONE;
							end
						end
					end
				end
			end else begin
				clear = 1'b1;
			end
		end

		if (clear) begin
			len_d        = '0;
			key_first_d  = '0;
			key_second_d = '0;
			eq_seen_d    = 1'b0;
			ended_d      = 1'b0;
			phase_d      = PH_SKIP_WS;
			neg_d        = 1'b0;
			mag_d        = '0;
			sat_d        = 1'b0;
			in_frac_d    = 1'b0;
			frac_cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			key_first_q  <= '0;
			key_second_q <= '0;
			eq_seen_q    <= 1'b0;
			ended_q      <= 1'b0;
			phase_q      <= PH_SKIP_WS;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			sat_q        <= 1'b0;
			in_frac_q    <= 1'b0;
			frac_cnt_q   <= '0;
		end else begin
			len_q        <= len_d;
			key_first_q  <= key_first_d;
			key_second_q <= key_second_d;
			eq_seen_q    <= eq_seen_d;
			ended_q      <= ended_d;
			phase_q      <= phase_d;
			neg_q        <= neg_d;
			mag_q        <= mag_d;
			sat_q        <= sat_d;
			in_frac_q    <= in_frac_d;
			frac_cnt_q   <= frac_cnt_d;
		end
	end

	// End-of-line decode from the state held before the terminator.
	always_comb begin
		km              = key_lookup(key_first_q, key_second_q);
		res.hit         = take && is_term && (len_q != '0) && eq_seen_q && km.hit;
		res.key_code    = km.code;
		res.frac_digits = (km.code == KEY_IQ) ? frac_cnt_q : '0;
		if (km.code != KEY_VX && neg_q) begin
			res.value = sat_q ? NEG_MAX : (~mag_q + 1'b1);
		end else begin
			res.value = (sat_q || mag_q > POS_MAX) ? POS_MAX : mag_q;
		end
	end

endmodule
